FILE: hw/rtl/mrla_pkg.sv
`default_nettype none

package mrla_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 8;

    // Default line store depth
    localparam int LINE_CAPACITY_DEF = 64;

    // Line terminators
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIVER_LINES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_CHAR    = 8'd1;

endpackage

`default_nettype wire

FILE: hw/rtl/modem_reply_line_assembler.sv
`default_nettype none

// Reply line assembler: received bytes are written into a single-port line
// memory while a line is collected. A CR or LF that ends a non-empty line
// with delivery enabled starts readout: each stored byte is read from the
// memory (ST_READ) and then loaded into the output register (ST_LOAD); the
// read waits while the consumer holds out_ready low with a byte pending, and
// no input is taken until the line has been emitted. A byte with rx_error
// set or equal to error_char discards the partial line, as does a byte
// arriving when LINE_CAPACITY-1 bytes are already held. The line memory
// needs no clearing after reset. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while the block is idle.
module modem_reply_line_assembler #(
    parameter int LINE_CAPACITY = mrla_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Received byte channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mrla_pkg::BYTE_W-1:0]       rx_byte,
    input  wire logic                              rx_error,
    // Line output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mrla_pkg::BYTE_W-1:0]            line_byte,
    output logic                                   line_last,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mrla_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mrla_pkg::BYTE_W-1:0]       cfg_data
);
    import mrla_pkg::*;

    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam logic [ADDR_W-1:0] LEN_MAX = ADDR_W'(LINE_CAPACITY - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [BYTE_W-1:0] line_mem [LINE_CAPACITY];

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] line_byte_reg;
    logic              line_last_reg;
    logic              deliver_reg;
    logic [BYTE_W-1:0] error_char_reg;

    logic in_fire;
    logic is_discard;
    logic is_term;
    logic slot_free;
    logic wr_en;
    logic rd_en;
    logic is_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign line_last = line_last_reg;

    assign in_fire    = in_valid && in_ready;
    assign is_discard = rx_error || (rx_byte == error_char_reg);
    assign is_term    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign slot_free  = !out_valid_reg || out_ready;
    assign rd_en      = (state_reg == ST_READ) && slot_free;
    assign is_last    = (rd_ptr_reg == last_idx_reg);
    assign wr_en      = in_fire && !is_discard && !is_term && (len_reg != LEN_MAX);

    // Next-state logic for collection and readout
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        rd_ptr_next    = rd_ptr_reg;
        last_idx_next  = last_idx_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_discard)
                    begin
                        len_next = '0;
                    end
                    else if (is_term)
                    begin
                        if (len_reg != '0)
                        begin
                            if (deliver_reg)
                            begin
                                rd_ptr_next   = '0;
                                last_idx_next = len_reg - 1'b1;
                                state_next    = ST_READ;
                            end
                            len_next = '0;
                        end
                    end
                    else if (len_reg == LEN_MAX)
                    begin
                        len_next = '0;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // Wait until the output register frees up
                if (slot_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                out_valid_next = 1'b1;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            rd_ptr_reg     <= '0;
            last_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            deliver_reg    <= 1'b0;
            error_char_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_ptr_reg    <= rd_ptr_next;
            last_idx_reg  <= last_idx_next;
            out_valid_reg <= out_valid_next;
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DELIVER_LINES)
                begin
                    deliver_reg <= cfg_data[0];
                end
                else if (cfg_index == CFG_ERROR_CHAR)
                begin
                    error_char_reg <= cfg_data;
                end
            end
        end
    end

    // Line memory: write while collecting, registered read during readout
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[len_reg] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_ptr_reg];
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            line_byte_reg <= rd_data_reg;
            line_last_reg <= is_last;
        end
    end

    // Output register is empty whenever a byte is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !out_valid_reg)
        else $error("output register overwritten during readout");

    // The collecting line is empty for the whole readout
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (len_reg == '0))
        else $error("line length nonzero during readout");

    // Loading the final byte marks it last and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && is_last)
        |=> (state_reg == ST_IDLE && out_valid_reg && line_last_reg))
        else $error("final byte not marked or readout not finished");

    // A byte arriving at full length discards the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_discard && !is_term && len_reg == LEN_MAX)
        |=> (len_reg == '0))
        else $error("overflow did not discard the line");

endmodule

`default_nettype wire
